### hw/rtl/dtc_pkg.sv
// decision tree classifier: shared types and constants
// used by the channel interfaces, the walk sequencer and the top level
`default_nettype none

package dtc_pkg;

  typedef logic [7:0]         node_idx_t;
  typedef logic signed [7:0]  split_feat_t;
  typedef logic signed [15:0] fixed_t;
  typedef logic [7:0]         class_t;
  typedef logic [23:0]        step_total_t;

  localparam int unsigned CfgIdxW = 1;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FEATURE_COUNT = 1'd0;
  localparam cfg_idx_t CFG_BATCH_SIZE    = 1'd1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [6:0]  FEATURE_COUNT_RST = 7'd4;
  localparam logic [15:0] BATCH_SIZE_RST    = 16'd1;
  localparam step_total_t STEP_MAX          = 24'hFFFFFF;

  localparam logic OP_LOAD_NODE = 1'b0;
  localparam logic OP_FEATURE   = 1'b1;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_TEST,
    WALK_COMPARE,
    WALK_DONE
  } walk_state_e;

endpackage

`default_nettype wire

### hw/rtl/dtc_if.sv
// valid/ready channel interfaces of the decision tree classifier
// depends on dtc_pkg for the payload types
`default_nettype none

interface dtc_in_if;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  dtc_pkg::node_idx_t   node_index;
  dtc_pkg::split_feat_t split_feature;
  dtc_pkg::fixed_t      split_threshold;
  dtc_pkg::node_idx_t   left_child;
  dtc_pkg::node_idx_t   right_child;
  dtc_pkg::class_t      class_label;
  dtc_pkg::fixed_t      feature_value;

  modport source (
    output valid, opcode, node_index, split_feature, split_threshold,
           left_child, right_child, class_label, feature_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, node_index, split_feature, split_threshold,
           left_child, right_child, class_label, feature_value,
    output ready
  );
endinterface

interface dtc_out_if;
  logic                  valid;
  logic                  ready;
  dtc_pkg::class_t       predicted_class;
  logic                  batch_last;
  dtc_pkg::step_total_t  total_steps;

  modport source (
    output valid, predicted_class, batch_last, total_steps,
    input  ready
  );
  modport sink (
    input  valid, predicted_class, batch_last, total_steps,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/decision_tree_classifier_unit.sv
// decision tree classifier, top level
// in_i carries node loads and feature words, out_o carries one result word
// per sample. cfg port: cfg_we_i, cfg_idx_i (0 feature_count, 1 batch_size)
// and cfg_wdata_i; the user must write them only while the block is idle,
// the block itself does not enforce it. a load word or a non-final feature
// word is taken whenever the walker is idle. the final feature word of a
// sample starts a walk from node 0: each non-leaf step is a node table read,
// then a feature read and one signed compare. the result is loaded into the
// output register at the same edge at which in_i.ready comes back. the walk
// is capped at NODES steps.
// the result sits in an output register; if out_o is stalled the walker
// holds its result and in_i stays not ready until the register frees up.
// reset clears the feature store valid bits (unwritten features read zero),
// the feature, sample and step counters and the config registers
// (feature_count 4, batch_size 1). node table contents are undefined until
// loaded.
`default_nettype none

module decision_tree_classifier_unit #(
  parameter int unsigned NODES    = 256,
  parameter int unsigned FEATURES = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  dtc_in_if.sink                         in_i,
  dtc_out_if.source                      out_o,
  input  wire logic                      cfg_we_i,
  input  wire dtc_pkg::cfg_idx_t         cfg_idx_i,
  input  wire logic [dtc_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned NodeAw = $clog2(NODES);
  localparam int unsigned FeatAw = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int unsigned StepW  = $clog2(NODES + 1);
  localparam int unsigned NodeW  = 32 + 2 * NodeAw;

  typedef logic [NodeAw-1:0] slot_lut_t [256];

  function automatic slot_lut_t build_slot_lut();
    slot_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = NodeAw'(i % NODES);
    end
    return lut;
  endfunction

  localparam slot_lut_t SlotLut = build_slot_lut();

  logic [6:0]  feature_count_q;
  logic [15:0] batch_size_q;
  logic [6:0]  feat_cnt_q;
  logic [15:0] sample_cnt_q;
  dtc_pkg::step_total_t step_total_q;

  logic in_fire, load_fire, feat_fire;
  logic [7:0] need;
  logic [6:0] feat_cnt_next;
  logic sample_done;
  logic feat_wr_en;

  logic walk_idle;
  logic node_rd_en;
  logic [NodeAw-1:0] node_rd_addr;
  logic [NodeW-1:0]  node_rd_data;
  logic [NodeW-1:0]  node_wr_data;
  logic feat_rd_en, feat_in_range;
  logic [FeatAw-1:0] feat_rd_addr;
  dtc_pkg::fixed_t feat_rd_data;
  logic res_valid, res_ready;
  dtc_pkg::class_t res_class;
  logic [StepW-1:0] res_steps;

  logic out_valid_q;
  dtc_pkg::class_t out_class_q;
  logic out_last_q;
  dtc_pkg::step_total_t out_steps_q;

  logic [24:0] step_sum;
  dtc_pkg::step_total_t step_sat;
  logic [15:0] sample_next;
  logic [15:0] bsz;
  logic batch_end;

  assign in_i.ready = walk_idle;
  assign in_fire    = in_i.valid && in_i.ready;
  assign load_fire  = in_fire && (in_i.opcode == dtc_pkg::OP_LOAD_NODE);
  assign feat_fire  = in_fire && (in_i.opcode == dtc_pkg::OP_FEATURE);

  always_comb begin
    need = {1'b0, feature_count_q};
    if (need == 8'd0) begin
      need = 8'd1;
    end
    if (need > 8'(FEATURES)) begin
      need = 8'(FEATURES);
    end
  end

  assign feat_cnt_next = feat_cnt_q + 7'd1;
  assign sample_done   = {1'b0, feat_cnt_next} >= need;
  assign feat_wr_en    = feat_fire && ({1'b0, feat_cnt_q} < 8'(FEATURES));

  assign node_wr_data = {in_i.split_feature, in_i.split_threshold,
                         SlotLut[in_i.left_child], SlotLut[in_i.right_child],
                         in_i.class_label};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feature_count_q <= dtc_pkg::FEATURE_COUNT_RST;
      batch_size_q    <= dtc_pkg::BATCH_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtc_pkg::CFG_FEATURE_COUNT: feature_count_q <= cfg_wdata_i[6:0];
        dtc_pkg::CFG_BATCH_SIZE:    batch_size_q    <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_cnt_q <= '0;
    end else if (feat_fire) begin
      feat_cnt_q <= sample_done ? 7'd0 : feat_cnt_next;
    end
  end

  dtc_node_mem #(
    .DEPTH  (NODES),
    .ADDR_W (NodeAw),
    .DATA_W (NodeW)
  ) u_node_mem (
    .clk_i     (clk_i),
    .wr_en_i   (load_fire),
    .wr_addr_i (SlotLut[in_i.node_index]),
    .wr_data_i (node_wr_data),
    .rd_en_i   (node_rd_en),
    .rd_addr_i (node_rd_addr),
    .rd_data_o (node_rd_data)
  );

  dtc_feat_mem #(
    .FEATURES (FEATURES),
    .ADDR_W   (FeatAw)
  ) u_feat_mem (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (feat_wr_en),
    .wr_addr_i     (feat_cnt_q[FeatAw-1:0]),
    .wr_data_i     (in_i.feature_value),
    .rd_en_i       (feat_rd_en),
    .rd_in_range_i (feat_in_range),
    .rd_addr_i     (feat_rd_addr),
    .rd_data_o     (feat_rd_data)
  );

  dtc_walker #(
    .NODES    (NODES),
    .FEATURES (FEATURES),
    .NODE_AW  (NodeAw),
    .FEAT_AW  (FeatAw),
    .STEP_W   (StepW),
    .NODE_W   (NodeW)
  ) u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (feat_fire && sample_done),
    .idle_o          (walk_idle),
    .node_rd_en_o    (node_rd_en),
    .node_rd_addr_o  (node_rd_addr),
    .node_rd_data_i  (node_rd_data),
    .feat_rd_en_o    (feat_rd_en),
    .feat_in_range_o (feat_in_range),
    .feat_rd_addr_o  (feat_rd_addr),
    .feat_rd_data_i  (feat_rd_data),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_class_o     (res_class),
    .res_steps_o     (res_steps)
  );

  // batch bookkeeping at result time
  assign res_ready   = !out_valid_q || out_o.ready;
  assign step_sum    = {1'b0, step_total_q} + 25'(res_steps);
  assign step_sat    = step_sum[24] ? dtc_pkg::STEP_MAX : step_sum[23:0];
  assign sample_next = sample_cnt_q + 16'd1;
  assign bsz         = (batch_size_q == 16'd0) ? 16'd1 : batch_size_q;
  assign batch_end   = (sample_next >= bsz) || (sample_next == 16'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_cnt_q <= '0;
      step_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        sample_cnt_q <= batch_end ? 16'd0 : sample_next;
        step_total_q <= batch_end ? 24'd0 : step_sat;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_class_q <= res_class;
      out_last_q  <= batch_end;
      out_steps_q <= step_sat;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.predicted_class = out_class_q;
  assign out_o.batch_last      = out_last_q;
  assign out_o.total_steps     = out_steps_q;

endmodule

`default_nettype wire

### hw/rtl/dtc_node_mem.sv
// node table: one write port for node loads, one registered read port
// for the walk sequencer; no reset on the contents
`default_nettype none

module dtc_node_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 48
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hw/rtl/dtc_feat_mem.sv
// sample feature store with per-entry valid bits so unwritten entries read zero
// registered read; out-of-range feature indexes read zero
`default_nettype none

module dtc_feat_mem #(
  parameter int unsigned FEATURES = 64,
  parameter int unsigned ADDR_W   = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire dtc_pkg::fixed_t   wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic              rd_in_range_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output dtc_pkg::fixed_t        rd_data_o
);

  dtc_pkg::fixed_t mem_q [FEATURES];
  logic [FEATURES-1:0] valid_q;
  dtc_pkg::fixed_t rd_data_q;
  logic rd_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= rd_in_range_i && valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

`default_nettype wire

### hw/rtl/dtc_walker.sv
// tree walk sequencer: fetches a node, fetches its feature, one shared
// signed compare picks the child; stops at a leaf or after NODES steps
`default_nettype none

module dtc_walker #(
  parameter int unsigned NODES    = 256,
  parameter int unsigned FEATURES = 64,
  parameter int unsigned NODE_AW  = 8,
  parameter int unsigned FEAT_AW  = 6,
  parameter int unsigned STEP_W   = 9,
  parameter int unsigned NODE_W   = 48
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    idle_o,
  output logic                    node_rd_en_o,
  output logic [NODE_AW-1:0]      node_rd_addr_o,
  input  wire logic [NODE_W-1:0]  node_rd_data_i,
  output logic                    feat_rd_en_o,
  output logic                    feat_in_range_o,
  output logic [FEAT_AW-1:0]      feat_rd_addr_o,
  input  wire dtc_pkg::fixed_t    feat_rd_data_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output dtc_pkg::class_t         res_class_o,
  output logic [STEP_W-1:0]       res_steps_o
);

  dtc_pkg::walk_state_e state_q, state_d;
  logic [NODE_AW-1:0] cur_q, cur_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  dtc_pkg::class_t    cls_q, cls_d;

  dtc_pkg::split_feat_t node_feat;
  dtc_pkg::fixed_t      node_thr;
  logic [NODE_AW-1:0]   child_lo;
  logic [NODE_AW-1:0]   child_hi;
  dtc_pkg::class_t      node_cls;
  logic                 go_left;

  assign node_cls   = node_rd_data_i[7:0];
  assign child_hi   = node_rd_data_i[8 +: NODE_AW];
  assign child_lo   = node_rd_data_i[8+NODE_AW +: NODE_AW];
  assign node_thr   = node_rd_data_i[8+2*NODE_AW +: 16];
  assign node_feat  = node_rd_data_i[24+2*NODE_AW +: 8];
  assign go_left    = feat_rd_data_i <= node_thr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtc_pkg::WALK_IDLE;
      cur_q   <= '0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
  end

  always_comb begin
    state_d         = state_q;
    cur_d           = cur_q;
    steps_d         = steps_q;
    cls_d           = cls_q;
    idle_o          = 1'b0;
    node_rd_en_o    = 1'b0;
    node_rd_addr_o  = cur_q;
    feat_rd_en_o    = 1'b0;
    feat_in_range_o = node_feat < 8'(FEATURES);
    feat_rd_addr_o  = node_feat[FEAT_AW-1:0];
    res_valid_o     = 1'b0;
    case (state_q)
      dtc_pkg::WALK_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          cur_d          = '0;
          steps_d        = '0;
          node_rd_en_o   = 1'b1;
          node_rd_addr_o = '0;
          state_d        = dtc_pkg::WALK_TEST;
        end
      end
      dtc_pkg::WALK_TEST: begin
        if (node_feat[7] || steps_q == STEP_W'(NODES)) begin
          cls_d   = node_cls;
          state_d = dtc_pkg::WALK_DONE;
        end else begin
          feat_rd_en_o = 1'b1;
          state_d      = dtc_pkg::WALK_COMPARE;
        end
      end
      dtc_pkg::WALK_COMPARE: begin
        cur_d          = go_left ? child_lo : child_hi;
        steps_d        = steps_q + STEP_W'(1);
        node_rd_en_o   = 1'b1;
        node_rd_addr_o = cur_d;
        state_d        = dtc_pkg::WALK_TEST;
      end
      dtc_pkg::WALK_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = dtc_pkg::WALK_IDLE;
        end
      end
      default: begin
        state_d = dtc_pkg::WALK_IDLE;
      end
    endcase
  end

  assign res_class_o = cls_q;
  assign res_steps_o = steps_q;

endmodule

`default_nettype wire
